FILE: rtl/multi_pattern_byte_matcher_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-pattern byte matcher
// Shorthands for clocked implications with reset disable.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_BYTE_MATCHER_TOP_MACROS_SVH
`define MULTI_PATTERN_BYTE_MATCHER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MPBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MPBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared widths, codes and types of the multi-pattern byte matcher.
// ----------------------------------------------------------------------------
package mpbm_pkg;

  // default sizes
  localparam int NUM_PATTERNS_DEF = 16;
  localparam int MAX_LEN_DEF      = 64;
  localparam int NUM_SLOTS_DEF    = 16;

  // field widths
  localparam int REQ_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int SEL_W   = 4;
  localparam int POS_W   = 6;
  localparam int LEN_W   = 6;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_DATA     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PAT_BYTE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PAT_LEN  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // one tracker entry: progress and saturating match total
  typedef struct packed {
    logic [LEN_W-1:0]   prog;
    logic [COUNT_W-1:0] total;
  } trk_word_t;

  // pattern store write request
  typedef struct packed {
    logic              wr_byte;
    logic              wr_len;
    logic [SEL_W-1:0]  sel;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } pat_wr_t;

endpackage

FILE: rtl/mpbm_if.sv
// ----------------------------------------------------------------------------
// mpbm channel interfaces
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface mpbm_in_if;
  logic                          valid;
  logic                          ready;
  logic [mpbm_pkg::REQ_W-1:0]    req_type;
  logic [mpbm_pkg::SLOT_W-1:0]   slot;
  logic                          is_store;
  logic [mpbm_pkg::BYTE_W-1:0]   data_byte;
  logic                          access_last;
  logic [mpbm_pkg::SEL_W-1:0]    pattern_sel;
  logic [mpbm_pkg::POS_W-1:0]    char_pos;
  logic [mpbm_pkg::LEN_W-1:0]    pattern_length;

  modport source (output valid, req_type, slot, is_store, data_byte, access_last,
                  pattern_sel, char_pos, pattern_length, input ready);
  modport sink   (input valid, req_type, slot, is_store, data_byte, access_last,
                  pattern_sel, char_pos, pattern_length, output ready);
endinterface

interface mpbm_out_if;
  logic                          valid;
  logic                          ready;
  logic [mpbm_pkg::KIND_W-1:0]   kind;
  logic [mpbm_pkg::SEL_W-1:0]    hit_pattern;
  logic [mpbm_pkg::COUNT_W-1:0]  hit_count;
  logic [mpbm_pkg::SLOT_W-1:0]   hit_slot;
  logic                          access_end;
  logic                          last;

  modport source (output valid, kind, hit_pattern, hit_count, hit_slot, access_end,
                  last, input ready);
  modport sink   (input valid, kind, hit_pattern, hit_count, hit_slot, access_end,
                  last, output ready);
endinterface

interface mpbm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mpbm_pkg::CFG_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/mpbm_pattern_mem.sv
// ----------------------------------------------------------------------------
// mpbm_pattern_mem
// Pattern byte store and pattern length table, both synchronous-read.
// ----------------------------------------------------------------------------
module mpbm_pattern_mem #(
  parameter int NUM_PATTERNS = mpbm_pkg::NUM_PATTERNS_DEF,
  parameter int MAX_LEN      = mpbm_pkg::MAX_LEN_DEF,
  localparam int PW          = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1
) (
  input  logic                        clk,
  input  mpbm_pkg::pat_wr_t           wr,
  input  logic                        len_rd_en,
  input  logic [PW-1:0]               len_rd_idx,
  input  logic                        byte_rd_en,
  input  logic [PW-1:0]               byte_rd_idx,
  input  logic [mpbm_pkg::POS_W-1:0]  byte_rd_pos,
  output logic [mpbm_pkg::LEN_W-1:0]  len_q,
  output logic [mpbm_pkg::BYTE_W-1:0] byte_q
);
  import mpbm_pkg::*;

  localparam int STORE_DEPTH = NUM_PATTERNS * MAX_LEN;
  localparam int SAW         = $clog2(STORE_DEPTH);

  logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
  logic [LEN_W-1:0]  len_mem   [NUM_PATTERNS];

  logic           sel_ok;
  logic           byte_we;
  logic           len_we;
  logic [SAW-1:0] wr_addr;
  logic [SAW-1:0] rd_addr;

  // out-of-range writes are dropped
  assign sel_ok  = int'(wr.sel) < NUM_PATTERNS;
  assign byte_we = wr.wr_byte && sel_ok && (int'(wr.pos) < MAX_LEN);
  assign len_we  = wr.wr_len && sel_ok;
  assign wr_addr = SAW'(int'(wr.sel) * MAX_LEN + int'(wr.pos));
  assign rd_addr = SAW'(int'(byte_rd_idx) * MAX_LEN + int'(byte_rd_pos));

  always_ff @(posedge clk) begin
    if (byte_we) begin
      store_mem[wr_addr] <= wr.data;
    end
    if (byte_rd_en) begin
      byte_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[PW'(wr.sel)] <= wr.len;
    end
    if (len_rd_en) begin
      len_q <= len_mem[len_rd_idx];
    end
  end

endmodule

FILE: rtl/multi_pattern_byte_matcher_top.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_top
// Per-slot, per-direction naive multi-pattern matcher over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : requests. Data bytes (slot, is_store, data_byte, access_last) and
//            pattern writes (pattern byte or pattern length).
//   out_ch : results. A data byte yields one match result per completed
//            pattern, in pattern order, then a byte-finished result with
//            last=1. A write yields one acknowledge with last=1.
//   cfg_ch : active pattern count, always ready; write it only while idle.
// Timing:
//   For a data byte the tracker memory (progress plus match total) is read,
//   checked against the pattern store and written back once per pattern, one
//   pattern issued per cycle unless a pending match stalls the pipeline,
//   through a three-stage read/read/update pipeline.
//   One item is in flight at a time; in_ch.ready is high only when idle.
// Reset:
//   rst_n low returns control to a clearing pass that zeroes every tracker
//   entry (NUM_SLOTS*2*NUM_PATTERNS entries), with in_ch.ready low.
// Stalls:
//   The result register holds until out_ch.ready; a pending match freezes the
//   whole pipeline, memory read registers included, until it is taken.
// ----------------------------------------------------------------------------
`include "multi_pattern_byte_matcher_top_macros.svh"

module multi_pattern_byte_matcher_top #(
  parameter int NUM_PATTERNS = mpbm_pkg::NUM_PATTERNS_DEF,
  parameter int MAX_LEN      = mpbm_pkg::MAX_LEN_DEF,
  parameter int NUM_SLOTS    = mpbm_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  mpbm_in_if.sink       in_ch,
  mpbm_out_if.source    out_ch,
  mpbm_cfg_if.sink      cfg_ch
);
  import mpbm_pkg::*;

  localparam int PW          = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int TRACK_DEPTH = NUM_SLOTS * 2 * NUM_PATTERNS;
  localparam int TW          = $clog2(TRACK_DEPTH);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,  // zeroing tracker memory
    ST_IDLE  = 5'b00010,  // waiting for a request
    ST_SCAN  = 5'b00100,  // walking the active patterns
    ST_FIN   = 5'b01000,  // sending byte-finished result
    ST_ACK   = 5'b10000   // sending write acknowledge
  } state_t;

  state_t state_r, state_nxt;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] cfg_act_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_act_r <= '0;
    end else if (cfg_ch.valid) begin
      cfg_act_r <= cfg_ch.data;
    end
  end

  // ---------------- request capture ----------------
  logic             in_accept;
  logic             is_data;
  logic             slot_ok;
  logic [CFG_W-1:0] act_clamp;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign is_data     = (in_ch.req_type == REQ_DATA);
  assign slot_ok     = int'(in_ch.slot) < NUM_SLOTS;
  assign act_clamp   = (int'(cfg_act_r) > NUM_PATTERNS) ? CFG_W'(NUM_PATTERNS) : cfg_act_r;

  logic [BYTE_W-1:0] byte_r;
  logic [SLOT_W-1:0] slot_r;
  logic              alast_r;
  logic [SEL_W-1:0]  sel_r;
  logic [TW-1:0]     base_r;
  logic [CFG_W-1:0]  act_eff_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r    <= in_ch.data_byte;
      slot_r    <= in_ch.slot;
      alast_r   <= in_ch.access_last;
      sel_r     <= in_ch.pattern_sel;
      act_eff_r <= act_clamp;
      base_r    <= TW'((int'(in_ch.slot) * 2 + int'(in_ch.is_store)) * NUM_PATTERNS);
    end
  end

  // ---------------- pattern memories ----------------
  pat_wr_t           pat_wr;
  logic [LEN_W-1:0]  len_q;
  logic [BYTE_W-1:0] pat_byte_q;

  assign pat_wr.wr_byte = in_accept && (in_ch.req_type == REQ_PAT_BYTE);
  assign pat_wr.wr_len  = in_accept && (in_ch.req_type == REQ_PAT_LEN);
  assign pat_wr.sel     = in_ch.pattern_sel;
  assign pat_wr.pos     = in_ch.char_pos;
  assign pat_wr.data    = in_ch.data_byte;
  assign pat_wr.len     = in_ch.pattern_length;

  // ---------------- pipeline control ----------------
  // stage 0: issue pattern p_r, read tracker and length
  // stage 1: tracker data back, read pattern byte at progress
  // stage 2: compare, update, write tracker, maybe emit match
  logic [CFG_W-1:0] p_r;
  logic             s1_valid_r;
  logic [CFG_W-1:0] s1_p_r;
  logic [TW-1:0]    s1_t_r;
  logic             s2_valid_r;
  logic [CFG_W-1:0] s2_p_r;
  logic [TW-1:0]    s2_t_r;
  logic [LEN_W-1:0] s2_prog_r;
  logic [COUNT_W-1:0] s2_total_r;
  logic [LEN_W-1:0] s2_len_r;
  logic             s2_inrange_r;
  trk_word_t        trk_rd_r;

  logic adv;
  logic issue;
  logic out_free;
  logic out_valid_r;
  logic [TW-1:0] trk_rd_addr;

  // update stage results
  logic             s2_hit;
  logic [LEN_W-1:0] s2_prog_new;
  logic             s2_match;
  logic [LEN_W-1:0] s2_prog_wr;
  logic [COUNT_W-1:0] s2_total_new;

  assign s2_hit       = s2_inrange_r && (pat_byte_q == byte_r);
  assign s2_prog_new  = s2_hit ? (s2_prog_r + LEN_W'(1)) : '0;
  assign s2_match     = (s2_len_r != '0) && (s2_prog_new == s2_len_r);
  assign s2_prog_wr   = s2_match ? '0 : s2_prog_new;
  assign s2_total_new = (s2_match && (s2_total_r != COUNT_MAX)) ?
                        (s2_total_r + COUNT_W'(1)) : s2_total_r;

  assign out_free    = !out_valid_r || out_ch.ready;
  // freeze everything while a match waits for the result register
  assign adv         = !(s2_valid_r && s2_match && !out_free);
  assign issue       = (state_r == ST_SCAN) && (p_r != act_eff_r) && adv;
  assign trk_rd_addr = base_r + TW'(p_r);

  mpbm_pattern_mem #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .MAX_LEN      (MAX_LEN)
  ) u_pattern_mem (
    .clk         (clk),
    .wr          (pat_wr),
    .len_rd_en   (issue),
    .len_rd_idx  (PW'(p_r)),
    .byte_rd_en  (s1_valid_r && adv),
    .byte_rd_idx (PW'(s1_p_r)),
    .byte_rd_pos (trk_rd_r.prog),
    .len_q       (len_q),
    .byte_q      (pat_byte_q)
  );

  // ---------------- tracker memory ----------------
  trk_word_t     trk_mem [TRACK_DEPTH];
  logic [TW-1:0] clr_addr_r;
  logic          trk_we;
  logic [TW-1:0] trk_wa;
  trk_word_t     trk_wd;

  assign trk_we = (state_r == ST_CLEAR) || (s2_valid_r && adv);
  assign trk_wa = (state_r == ST_CLEAR) ? clr_addr_r : s2_t_r;
  always_comb begin
    trk_wd = '0;
    if (state_r != ST_CLEAR) begin
      trk_wd.prog  = s2_prog_wr;
      trk_wd.total = s2_total_new;
    end
  end

  always_ff @(posedge clk) begin
    if (trk_we) begin
      trk_mem[trk_wa] <= trk_wd;
    end
    if (issue) begin
      trk_rd_r <= trk_mem[trk_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      clr_addr_r <= clr_addr_r + TW'(1);
    end
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r        <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        p_r <= '0;
      end else if (issue) begin
        p_r <= p_r + CFG_W'(1);
      end
      if (adv) begin
        s1_valid_r <= issue;
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_p_r <= p_r;
      s1_t_r <= trk_rd_addr;
    end
    if (adv && s1_valid_r) begin
      s2_p_r       <= s1_p_r;
      s2_t_r       <= s1_t_r;
      s2_prog_r    <= trk_rd_r.prog;
      s2_total_r   <= trk_rd_r.total;
      s2_len_r     <= len_q;
      s2_inrange_r <= int'(trk_rd_r.prog) < MAX_LEN;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == TW'(TRACK_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (!is_data) begin
            state_nxt = ST_ACK;
          end else if (slot_ok && (act_clamp != '0)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if ((p_r == act_eff_r) && !s1_valid_r && !s2_valid_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN, ST_ACK: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- result register ----------------
  logic load_match;
  logic load_fin;
  logic load_ack;

  logic [KIND_W-1:0]  kind_r;
  logic [SEL_W-1:0]   hit_pattern_r;
  logic [COUNT_W-1:0] hit_count_r;
  logic [SLOT_W-1:0]  hit_slot_r;
  logic               access_end_r;
  logic               last_r;

  assign load_match = s2_valid_r && s2_match && adv;
  assign load_fin   = (state_r == ST_FIN) && out_free;
  assign load_ack   = (state_r == ST_ACK) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_match || load_fin || load_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_match) begin
      kind_r        <= KIND_MATCH;
      hit_pattern_r <= SEL_W'(s2_p_r);
      hit_count_r   <= s2_total_new;
      hit_slot_r    <= slot_r;
      access_end_r  <= 1'b0;
      last_r        <= 1'b0;
    end else if (load_fin) begin
      kind_r        <= KIND_DONE;
      hit_pattern_r <= '0;
      hit_count_r   <= '0;
      hit_slot_r    <= slot_r;
      access_end_r  <= alast_r;
      last_r        <= 1'b1;
    end else if (load_ack) begin
      kind_r        <= KIND_ACK;
      hit_pattern_r <= sel_r;
      hit_count_r   <= '0;
      hit_slot_r    <= '0;
      access_end_r  <= 1'b0;
      last_r        <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.hit_pattern = hit_pattern_r;
  assign out_ch.hit_count   = hit_count_r;
  assign out_ch.hit_slot    = hit_slot_r;
  assign out_ch.access_end  = access_end_r;
  assign out_ch.last        = last_r;

  // ---------------- assertions ----------------
  `MPBM_ASSERT_SAME(a_accept_drained, clk, rst_n, in_accept, !s1_valid_r && !s2_valid_r, "request accepted with pipeline busy")
  `MPBM_ASSERT_SAME(a_clear_quiet, clk, rst_n, state_r == ST_CLEAR, !s2_valid_r && !out_valid_r, "tracker update during clearing pass")
  `MPBM_ASSERT_NEXT(a_stall_holds, clk, rst_n, s2_valid_r && !adv, s2_valid_r && $stable(s2_t_r), "update stage moved while stalled")
  `MPBM_ASSERT_SAME(a_issue_bound, clk, rst_n, state_r == ST_SCAN, p_r <= act_eff_r, "pattern counter ran past active count")
  `MPBM_ASSERT_NEXT(a_match_out, clk, rst_n, load_match, out_valid_r && (out_ch.kind == KIND_MATCH), "match not presented")

endmodule

FILE: tb/sv/multi_pattern_byte_matcher_top_tb.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_top_tb
// Self-checking bench for the multi-pattern byte matcher. A behavioral copy of
// the pattern store, the pattern lengths and the per-slot trackers predicts
// every result, and results are checked in order as they are handed over.
// Directed corner tests run first, then random traffic partly under random
// stalls on both channels, then a long run that saturates one match total.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher_top_tb;
  import mpbm_pkg::*;

  // request code with no function; the block acks it like a write
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int TRACKERS       = NUM_SLOTS_DEF * 2 * NUM_PATTERNS_DEF;
  // covers one data byte passing through every searched pattern, with margin
  localparam int SETTLE_CYCLES  = NUM_PATTERNS_DEF + 8;
  localparam int GAP_MAX        = 17;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 84;
  // two more than needed to reach 65535, so the stop at the top is seen
  localparam int SATURATE_ITEMS = 65537;
  localparam int MAX_REPORTS    = 10;
  localparam int END_WAIT       = 20000;
  // Slowest legal run: ~1.6k items at 17 results each, every result stalled
  // the most, plus 64k saturation bytes at full rate, plus the clearing pass
  // after reset; the limit is roughly four times that.
  localparam int unsigned CYCLE_LIMIT = 6_000_000;

  localparam logic [BYTE_W-1:0] MARK_BYTE = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_B    = 8'h42;

  // one input transfer, all fields
  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [SLOT_W-1:0] slot;
    logic              is_store;
    logic [BYTE_W-1:0] data;
    logic              alast;
    logic [SEL_W-1:0]  sel;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
  } req_t;

  // one result transfer, in port order
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SEL_W-1:0]   hit_pattern;
    logic [COUNT_W-1:0] hit_count;
    logic [SLOT_W-1:0]  hit_slot;
    logic               access_end;
    logic               last;
  } result_t;

  logic clk;
  logic rst_n;

  mpbm_in_if  in_ch ();
  mpbm_out_if out_ch ();
  mpbm_cfg_if cfg_ch ();

  multi_pattern_byte_matcher_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // Predictor state: mirrors what the block holds.
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0]  pat_bytes   [NUM_PATTERNS_DEF][MAX_LEN_DEF];
  logic [LEN_W-1:0]   pat_lens    [NUM_PATTERNS_DEF];
  logic [LEN_W-1:0]   track_prog  [TRACKERS];
  logic [COUNT_W-1:0] track_total [TRACKERS];
  logic [CFG_W-1:0]   active_cfg;

  // results predicted but not yet seen, oldest first
  result_t awaited_results [$];

  int          fail_count    = 0;
  int unsigned cycle_count   = 0;
  int          send_gap_max  = GAP_MAX;
  int          stall_max     = GAP_MAX;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("multi_pattern_byte_matcher_top test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic void flag_error(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("ERROR cycle %0d: %s", cycle_count, msg);
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf("kind=%0d pattern=%0d count=%0d slot=%0d end=%0b last=%0b",
                     r.kind, r.hit_pattern, r.hit_count, r.hit_slot, r.access_end,
                     r.last);
  endfunction

  function automatic result_t pack_result(logic [KIND_W-1:0] kind,
                                          logic [SEL_W-1:0] pat,
                                          logic [COUNT_W-1:0] count,
                                          logic [SLOT_W-1:0] slot,
                                          logic aend, logic last);
    result_t r;
    r.kind        = kind;
    r.hit_pattern = pat;
    r.hit_count   = count;
    r.hit_slot    = slot;
    r.access_end  = aend;
    r.last        = last;
    return r;
  endfunction

  // register value above NUM_PATTERNS searches all of them
  function automatic int searched_patterns();
    return (active_cfg > NUM_PATTERNS_DEF) ? NUM_PATTERNS_DEF : int'(active_cfg);
  endfunction

  function automatic int tracker_index(logic [SLOT_W-1:0] slot, logic is_store,
                                       int pat);
    return (int'(slot) * 2 + int'(is_store)) * NUM_PATTERNS_DEF + pat;
  endfunction

  // small alphabet most of the time so patterns recur in the traffic
  function automatic logic [BYTE_W-1:0] pick_symbol();
    logic [BYTE_W-1:0] few [4];
    few = '{MARK_BYTE, 8'hA5, 8'h00, 8'hFF};
    if ($urandom_range(3, 0) == 0)
      return BYTE_W'($urandom);
    return few[$urandom_range(3, 0)];
  endfunction

  // every field random but the request code (data); callers overwrite the ones that matter
  function automatic req_t random_req();
    req_t r;
    r.req      = REQ_DATA;
    r.slot     = SLOT_W'($urandom);
    r.is_store = 1'($urandom);
    r.data     = BYTE_W'($urandom);
    r.alast    = 1'($urandom);
    r.sel      = SEL_W'($urandom);
    r.pos      = POS_W'($urandom);
    r.len      = LEN_W'($urandom);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted request and queues the results it causes.
  // Writes get a single ack. A data byte walks the searched patterns in order;
  // a hit advances that tracker's progress, a miss drops it to zero without a
  // second compare at position zero. Reaching a nonzero length bumps the
  // saturating total and emits a match. A byte-finished result closes it.
  // --------------------------------------------------------------------------
  function automatic void matcher_outcome(req_t r);
    int p;
    int idx;
    int act;
    logic [LEN_W-1:0] pr;
    if (r.req != REQ_DATA) begin
      if (r.req == REQ_PAT_BYTE)
        pat_bytes[r.sel][r.pos] = r.data;
      else if (r.req == REQ_PAT_LEN)
        pat_lens[r.sel] = r.len;
      awaited_results.push_back(pack_result(KIND_ACK, r.sel, '0, '0, 1'b0, 1'b1));
    end else begin
      act = searched_patterns();
      for (p = 0; p < act; p++) begin
        idx = tracker_index(r.slot, r.is_store, p);
        pr  = track_prog[idx];
        // progress is 6 bits, so a shortened length lets it wrap
        pr  = (pat_bytes[p][pr] == r.data) ? pr + 1'b1 : '0;
        if (pat_lens[p] != '0 && pr == pat_lens[p]) begin
          if (track_total[idx] != COUNT_MAX)
            track_total[idx] = track_total[idx] + 1'b1;
          pr = '0;
          awaited_results.push_back(pack_result(KIND_MATCH, SEL_W'(p), track_total[idx],
                                                r.slot, 1'b0, 1'b0));
        end
        track_prog[idx] = pr;
      end
      awaited_results.push_back(pack_result(KIND_DONE, '0, '0, r.slot, r.alast, 1'b1));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Valid is left high after a transfer so a back-to-back item never
  // sees valid lowered and raised in one step; anything that lets time pass
  // between items drops valid first.
  // --------------------------------------------------------------------------
  task automatic send_req(input req_t r);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= r.req;
    in_ch.slot           <= r.slot;
    in_ch.is_store       <= r.is_store;
    in_ch.data_byte      <= r.data;
    in_ch.access_last    <= r.alast;
    in_ch.pattern_sel    <= r.sel;
    in_ch.char_pos       <= r.pos;
    in_ch.pattern_length <= r.len;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    matcher_outcome(r);
  endtask

  task automatic data_req(input logic [SLOT_W-1:0] slot, input logic is_store,
                          input logic [BYTE_W-1:0] data, input logic alast);
    req_t r;
    r          = random_req();
    r.slot     = slot;
    r.is_store = is_store;
    r.data     = data;
    r.alast    = alast;
    send_req(r);
  endtask

  task automatic pat_byte_write(input logic [SEL_W-1:0] sel, input logic [POS_W-1:0] pos,
                                input logic [BYTE_W-1:0] data);
    req_t r;
    r      = random_req();
    r.req  = REQ_PAT_BYTE;
    r.sel  = sel;
    r.pos  = pos;
    r.data = data;
    send_req(r);
  endtask

  task automatic pat_len_write(input logic [SEL_W-1:0] sel, input logic [LEN_W-1:0] len);
    req_t r;
    r     = random_req();
    r.req = REQ_PAT_LEN;
    r.sel = sel;
    r.len = len;
    send_req(r);
  endtask

  // sender holds off until every predicted result has been seen, then lets
  // the pipeline finish its write-back
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_active(input logic [CFG_W-1:0] value);
    wait_results_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    active_cfg = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: random stall before each transfer, then compare with the
  // oldest prediction.
  // --------------------------------------------------------------------------
  initial begin
    result_t got;
    result_t want;
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(stall_max, 0);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      got.kind        = out_ch.kind;
      got.hit_pattern = out_ch.hit_pattern;
      got.hit_count   = out_ch.hit_count;
      got.hit_slot    = out_ch.hit_slot;
      got.access_end  = out_ch.access_end;
      got.last        = out_ch.last;
      if (awaited_results.size() == 0) begin
        flag_error({"unexpected result: ", fmt_result(got)});
      end else begin
        want = awaited_results.pop_front();
        if (got !== want)
          flag_error({"mismatch\n  expected: ", fmt_result(want),
                      "\n  actual:   ", fmt_result(got)});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset state: no pattern searched, so a byte only yields byte finished.
  // Slot, direction and byte extremes, plus the unused request code.
  task automatic test_idle_defaults();
    req_t r;
    r     = random_req();
    r.req = REQ_UNUSED;
    r.sel = 4'd15;
    send_req(r);
    write_active('0);
    data_req(4'd0,  1'b0, 8'h00, 1'b1);
    data_req(4'd15, 1'b1, 8'hFF, 1'b0);
    data_req(4'd0,  1'b1, 8'hFF, 1'b0);
    data_req(4'd15, 1'b0, 8'h00, 1'b1);
  endtask

  // Fill every pattern byte and length so no later read hits an unwritten
  // entry. All lengths 1 with MARK_BYTE first: one byte then matches all.
  // Runs with no idling on either side.
  task automatic load_pattern_store();
    int p;
    int k;
    send_gap_max = 0;
    stall_max    = 0;
    for (p = 0; p < NUM_PATTERNS_DEF; p++) begin
      pat_len_write(SEL_W'(p), LEN_W'(1));
      for (k = 0; k < MAX_LEN_DEF; k++)
        pat_byte_write(SEL_W'(p), POS_W'(k), (k == 0) ? MARK_BYTE : pick_symbol());
    end
    send_gap_max = GAP_MAX;
    stall_max    = GAP_MAX;
  endtask

  // Register above NUM_PATTERNS clamps; one byte then completes all 16
  // patterns, the most results one item can cause.
  task automatic test_max_results();
    write_active(CFG_W'(31));
    data_req(4'd7, 1'b1, MARK_BYTE, 1'b1);
    data_req(4'd7, 1'b1, MARK_BYTE, 1'b0);
    write_active(CFG_W'(NUM_PATTERNS_DEF));
    data_req(4'd7, 1'b0, MARK_BYTE, 1'b1);
  endtask

  // "AAB": after A,A a third A misses and is not retried at position zero,
  // so A,A,A,B never matches; A,A,B afterwards does.
  task automatic test_miss_without_retest();
    logic [BYTE_W-1:0] stream [7];
    int k;
    stream = '{CHAR_A, CHAR_A, CHAR_A, CHAR_B, CHAR_A, CHAR_A, CHAR_B};
    write_active(CFG_W'(2));
    pat_byte_write(4'd1, 6'd0, CHAR_A);
    pat_byte_write(4'd1, 6'd1, CHAR_A);
    pat_byte_write(4'd1, 6'd2, CHAR_B);
    pat_len_write(4'd1, 6'd3);
    for (k = 0; k < 7; k++)
      data_req(4'd5, 1'b0, stream[k], 1'($urandom));
  endtask

  // Zero length never matches; a length cut below the current progress lets
  // progress run on past it; the longest length is accepted.
  task automatic test_length_corners();
    int k;
    write_active(CFG_W'(4));
    pat_len_write(4'd2, 6'd0);
    pat_len_write(4'd3, 6'd4);
    for (k = 0; k < 3; k++)
      data_req(4'd11, 1'b1, pat_bytes[3][k], 1'b0);
    pat_len_write(4'd3, 6'd2);
    data_req(4'd11, 1'b1, pat_bytes[3][3], 1'b1);
    pat_len_write(4'd1, 6'd63);
    data_req(4'd5, 1'b0, CHAR_A, 1'b1);
  endtask

  // Random traffic in phases with different register values and idling.
  // Most data bytes continue a pattern on some tracker so matches come
  // often; the rest are random bytes, pattern rewrites and unused requests.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] settings [RANDOM_PHASES];
    req_t r;
    int ph;
    int n;
    int p;
    int act;
    int roll;
    settings[0] = CFG_W'(NUM_PATTERNS_DEF);
    settings[1] = CFG_W'($urandom_range(NUM_PATTERNS_DEF - 1, 2));
    settings[2] = CFG_W'(1);
    settings[3] = CFG_W'($urandom_range(31, NUM_PATTERNS_DEF + 1));
    settings[4] = CFG_W'(NUM_PATTERNS_DEF);
    // short lengths so patterns complete often
    for (p = 0; p < NUM_PATTERNS_DEF; p++)
      pat_len_write(SEL_W'(p), LEN_W'($urandom_range(4, 1)));
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_active(settings[ph]);
      // some phases without idling on one side or both
      send_gap_max = (ph == 1 || ph == 2) ? 0 : GAP_MAX;
      stall_max    = (ph == 2 || ph == 3) ? 0 : GAP_MAX;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r    = random_req();
        act  = searched_patterns();
        roll = $urandom_range(99, 0);
        if (roll < 70 && act > 0) begin
          // next byte of a pattern on this tracker
          p      = $urandom_range(act - 1, 0);
          r.data = pat_bytes[p][track_prog[tracker_index(r.slot, r.is_store, p)]];
        end else if (roll < 84) begin
          r.req = REQ_DATA;
        end else if (roll < 93) begin
          r.req  = REQ_PAT_BYTE;
          r.data = pick_symbol();
        end else if (roll < 98) begin
          r.req = REQ_PAT_LEN;
          r.len = ($urandom_range(3, 0) == 0) ? LEN_W'($urandom_range(63, 0))
                                               : LEN_W'($urandom_range(4, 1));
        end else begin
          r.req = REQ_UNUSED;
        end
        send_req(r);
      end
    end
    send_gap_max = GAP_MAX;
    stall_max    = GAP_MAX;
  endtask

  // One-byte pattern matched on every byte of one tracker until its total
  // sticks at the top. Full rate on both sides to keep the run short.
  task automatic test_match_saturation();
    int n;
    write_active(CFG_W'(1));
    pat_byte_write(4'd0, 6'd0, MARK_BYTE);
    pat_len_write(4'd0, 6'd1);
    send_gap_max = 0;
    stall_max    = 0;
    for (n = 0; n < SATURATE_ITEMS; n++)
      data_req(4'd9, 1'b0, MARK_BYTE, 1'($urandom));
    send_gap_max = GAP_MAX;
    stall_max    = GAP_MAX;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int p;
    int k;
    int end_wait;
    // all inputs known from time zero
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.req_type       <= '0;
    in_ch.slot           <= '0;
    in_ch.is_store       <= 1'b0;
    in_ch.data_byte      <= '0;
    in_ch.access_last    <= 1'b0;
    in_ch.pattern_sel    <= '0;
    in_ch.char_pos       <= '0;
    in_ch.pattern_length <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.data          <= '0;

    // predictor after reset; pattern entries are filled before any read
    for (p = 0; p < NUM_PATTERNS_DEF; p++) begin
      pat_lens[p] = '0;
      for (k = 0; k < MAX_LEN_DEF; k++)
        pat_bytes[p][k] = '0;
    end
    for (k = 0; k < TRACKERS; k++) begin
      track_prog[k]  = '0;
      track_total[k] = '0;
    end
    active_cfg = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // the clearing pass after reset holds in_ch.ready low; send_req waits it out
    test_idle_defaults();
    load_pattern_store();
    test_max_results();
    test_miss_without_retest();
    test_length_corners();
    test_random_traffic();
    test_match_saturation();

    // wind down: all results in, then a few quiet cycles for strays
    in_ch.valid <= 1'b0;
    end_wait = 0;
    while (awaited_results.size() != 0 && end_wait < END_WAIT) begin
      @(posedge clk);
      end_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", awaited_results.size()));

    if (fail_count == 0) begin
      $display("multi_pattern_byte_matcher_top test passed");
    end else begin
      $display("multi_pattern_byte_matcher_top test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/mpbm_pkg.sv
rtl/mpbm_if.sv
rtl/mpbm_pattern_mem.sv
rtl/multi_pattern_byte_matcher_top.sv
tb/sv/multi_pattern_byte_matcher_top_tb.sv
